[hdl/ufa_pkg.sv]
// ufa_pkg: shared constants, operation codes and payload structs for the
// unsigned fixed-point alu. No dependencies; imported by every hdl module.
`default_nettype none

package ufa_pkg;

  // number formats
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned OP_W      = 4;
  localparam int unsigned PROD_W    = 2 * DATA_W;

  // divider geometry: dividend is the first operand shifted left by FRAC_BITS
  localparam int unsigned DIVD_W     = DATA_W + FRAC_BITS;
  localparam int unsigned DIV_STEP   = 4;
  localparam int unsigned DIV_STAGES = (DIVD_W + DIV_STEP - 1) / DIV_STEP;
  localparam int unsigned DIVP_W     = DIV_STAGES * DIV_STEP;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_EQ  = 4'd4,
    OP_NE  = 4'd5,
    OP_LT  = 4'd6,
    OP_LE  = 4'd7,
    OP_GT  = 4'd8,
    OP_GE  = 4'd9
  } op_e;

  // request transfer payload
  typedef struct packed {
    logic [OP_W-1:0]   req_type;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
  } req_t;

  // result transfer payload
  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic              divide_by_zero;
  } rsp_t;

  // non-divide path result, aligned with the divider output
  typedef struct packed {
    logic              is_div;
    logic              div_zero;
    logic [DATA_W-1:0] value;
  } alu_res_t;

  // one divider pipeline stage
  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DIVP_W-1:0] num;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] divisor;
  } div_t;

endpackage

`default_nettype wire

[hdl/unsigned_fixed_point_alu.sv]
// unsigned_fixed_point_alu: top level, input register, valid pipeline and
// result register. Depends on ufa_pkg, ufa_divider and ufa_alu.
//
// Usage:
//   A request (req_i: req_type, operand_a, operand_b) is transferred at a
//   rising edge where start is high and busy is low. busy is always low, so
//   a new request may be issued every cycle; requests are independent.
//   Each request yields exactly one result on rsp_o (result_value,
//   divide_by_zero), shown for one cycle while done_o is high, in request
//   order. The receiver cannot stall and must take it in that cycle.
//   Path: the request passes the input register, the DIV_STAGES divider
//   stages, with DIV_STAGES = ceil((16 + FRAC_BITS) / 4), and the result
//   register. The depth is set by the divider, which
//   retires four quotient bits per stage; all other operations are delayed
//   to the same depth so results stay in order.
//   Throughput: one request per cycle.
//   Reset: rst_ni clears all valid bits; no result is shown afterwards until
//   a new request arrives. Datapath registers are not reset.
//   Divide by zero returns all ones with divide_by_zero set; unknown codes
//   return zero.
`default_nettype none

module unsigned_fixed_point_alu (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire ufa_pkg::req_t req_i,
  output logic               done_o,
  output ufa_pkg::rsp_t      rsp_o
);
  import ufa_pkg::*;

  localparam int unsigned LATENCY = DIV_STAGES + 2;

  logic                  accept;
  req_t                  req_q;
  logic [DIV_STAGES:0]   vld_q;
  logic [DATA_W-1:0]     quotient;
  alu_res_t              alu_res;
  rsp_t                  rsp_d;
  rsp_t                  rsp_q;
  logic                  done_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // input register
  always_ff @(posedge clk_i) begin
    req_q <= req_i;
  end

  // valid bits travel alongside the datapath stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[DIV_STAGES-1:0], accept};
      done_q <= vld_q[DIV_STAGES];
    end
  end

  ufa_divider u_div (
    .clk_i       (clk_i),
    .operand_a_i (req_q.operand_a),
    .operand_b_i (req_q.operand_b),
    .quotient_o  (quotient)
  );

  ufa_alu u_alu (
    .clk_i (clk_i),
    .req_i (req_q),
    .res_o (alu_res)
  );

  // merge divider and alu paths
  always_comb begin
    if (alu_res.is_div) begin
      rsp_d.result_value   = alu_res.div_zero ? '1 : quotient;
      rsp_d.divide_by_zero = alu_res.div_zero;
    end else begin
      rsp_d.result_value   = alu_res.value;
      rsp_d.divide_by_zero = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // every transferred request gives a result
  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(LATENCY) done_o)
    else $error("result missing for transferred request");

  // no result without a matching request
  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result without a request");

  // zero divisor sets the flag
  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.req_type == OP_DIV && req_i.operand_b == '0)
      |-> ##(LATENCY) (done_o && rsp_o.divide_by_zero))
    else $error("divide by zero not flagged");

  // flag only with all-ones result
  a_flag_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.divide_by_zero) |-> (rsp_o.result_value == '1))
    else $error("divide by zero result not all ones");

endmodule

`default_nettype wire

[hdl/ufa_divider.sv]
// ufa_divider: pipelined restoring divider, DIV_STEP quotient bits per stage,
// DIV_STAGES register stages. Depends on ufa_pkg.
`default_nettype none

module ufa_divider (
  input  wire logic                       clk_i,
  input  wire logic [ufa_pkg::DATA_W-1:0] operand_a_i,
  input  wire logic [ufa_pkg::DATA_W-1:0] operand_b_i,
  output logic      [ufa_pkg::DATA_W-1:0] quotient_o
);
  import ufa_pkg::*;

  // DIV_STEP restoring steps; remainder stays below the divisor
  function automatic div_t div_steps(div_t s);
    div_t            r;
    logic [DATA_W:0] t;
    logic [DATA_W:0] diff;
    r = s;
    for (int i = 0; i < DIV_STEP; i++) begin
      t     = {r.rem, r.num[DIVP_W-1]};
      diff  = t - {1'b0, r.divisor};
      r.num = {r.num[DIVP_W-2:0], 1'b0};
      if (t >= {1'b0, r.divisor}) begin
        r.rem = diff[DATA_W-1:0];
        r.quo = {r.quo[DATA_W-2:0], 1'b1};
      end else begin
        r.rem = t[DATA_W-1:0];
        r.quo = {r.quo[DATA_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  div_t init;
  div_t stg_q [DIV_STAGES];

  // dividend is the first operand scaled up by the fraction bits
  always_comb begin
    init.rem     = '0;
    init.num     = DIVP_W'({operand_a_i, {FRAC_BITS{1'b0}}});
    init.quo     = '0;
    init.divisor = operand_b_i;
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    stg_q[0] <= div_steps(init);
    for (int k = 1; k < DIV_STAGES; k++) begin
      stg_q[k] <= div_steps(stg_q[k-1]);
    end
  end

  assign quotient_o = stg_q[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

[hdl/ufa_alu.sv]
// ufa_alu: add, subtract, multiply and compare path, delayed to line up with
// the divider pipeline (DIV_STAGES register stages). Depends on ufa_pkg.
`default_nettype none

module ufa_alu (
  input  wire logic              clk_i,
  input  wire ufa_pkg::req_t     req_i,
  output ufa_pkg::alu_res_t      res_o
);
  import ufa_pkg::*;

  req_t              p1_q;
  logic [PROD_W-1:0] prod_q;
  alu_res_t          res_d;
  alu_res_t          dly_q [DIV_STAGES-1];

  logic              lt;
  logic              eq;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] diff;

  // stage 1: full product
  always_ff @(posedge clk_i) begin
    p1_q   <= req_i;
    prod_q <= PROD_W'(req_i.operand_a) * PROD_W'(req_i.operand_b);
  end

  // stage 2: select the result
  always_comb begin
    lt   = p1_q.operand_a < p1_q.operand_b;
    eq   = p1_q.operand_a == p1_q.operand_b;
    sum  = {1'b0, p1_q.operand_a} + {1'b0, p1_q.operand_b};
    diff = p1_q.operand_a - p1_q.operand_b;
    res_d.is_div   = (p1_q.req_type == OP_DIV);
    res_d.div_zero = (p1_q.operand_b == '0);
    unique case (p1_q.req_type)
      OP_ADD:  res_d.value = sum[DATA_W-1:0];
      OP_SUB:  res_d.value = lt ? '0 : diff;
      OP_MUL:  res_d.value = prod_q[FRAC_BITS +: DATA_W];
      OP_EQ:   res_d.value = {{(DATA_W-1){1'b0}}, eq};
      OP_NE:   res_d.value = {{(DATA_W-1){1'b0}}, !eq};
      OP_LT:   res_d.value = {{(DATA_W-1){1'b0}}, lt};
      OP_LE:   res_d.value = {{(DATA_W-1){1'b0}}, lt | eq};
      OP_GT:   res_d.value = {{(DATA_W-1){1'b0}}, !(lt | eq)};
      OP_GE:   res_d.value = {{(DATA_W-1){1'b0}}, !lt};
      default: res_d.value = '0;
    endcase
  end

  // delay line up to the divider depth
  always_ff @(posedge clk_i) begin
    dly_q[0] <= res_d;
    for (int k = 1; k < DIV_STAGES - 1; k++) begin
      dly_q[k] <= dly_q[k-1];
    end
  end

  assign res_o = dly_q[DIV_STAGES-2];

endmodule

`default_nettype wire
